// ===== rtl/core/cdl_pkg.sv =====
// shared types and constants of the code density table builder
package cdl_pkg;

   // width of the running bin sum, saturating
   localparam int SUM_WIDTH = 48;

   // entries of the queue between front and back, a power of two
   localparam int QUEUE_DEPTH = 2;

   // back end sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_ROUND
   } cdl_state_type;

   // queue status seen by front and back
   typedef struct packed {
      logic empty;
      logic full;
   } cdl_queue_status_type;

endpackage

// ===== rtl/core/cdl_front.sv =====
// front end: accepts bin words and keeps the saturating running sum
module cdl_front
   import cdl_pkg::*;
#(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [COUNT_WIDTH-1:0]               req_bin_count,
   input  logic                                 req_last_bin,
   input  cdl_queue_status_type                 q_status,
   output logic                                 q_push,
   output logic [SUM_WIDTH+COUNT_WIDTH:0]       q_push_data
);

   logic [SUM_WIDTH-1:0] running_sum_ff;
   logic [SUM_WIDTH-1:0] running_sum_in;
   logic [SUM_WIDTH:0]   sum_wide;
   logic [SUM_WIDTH-1:0] sum_sat;

   assign req_stall = q_status.full;
   assign q_push    = req_valid && !q_status.full;

   always_comb begin
      sum_wide = {1'b0, running_sum_ff} + (SUM_WIDTH+1)'(req_bin_count);
      // clip at all ones
      sum_sat  = sum_wide[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : sum_wide[SUM_WIDTH-1:0];
      running_sum_in = running_sum_ff;
      if (q_push) begin
         running_sum_in = req_last_bin ? '0 : sum_sat;
      end
   end

   assign q_push_data = {sum_sat, req_bin_count, req_last_bin};

   always_ff @(posedge clock) begin
      if (reset) begin
         running_sum_ff <= '0;
      end else begin
         running_sum_ff <= running_sum_in;
      end
   end

endmodule

// ===== rtl/core/cdl_queue.sv =====
// short queue between front and back
module cdl_queue
   import cdl_pkg::*;
#(
   parameter int DATA_WIDTH = 81
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [DATA_WIDTH-1:0] push_data,
   input  logic                  pop,
   output logic [DATA_WIDTH-1:0] head_data,
   output cdl_queue_status_type  status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_WIDTH-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff;
   logic [PTR_W-1:0]      rd_ptr_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [PTR_W-1:0]      wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_in;
   logic [CNT_W-1:0]      count_in;
   logic                  do_push;
   logic                  do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_data    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // occupancy never runs past the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue occupancy beyond depth");

endmodule

// ===== rtl/core/cdl_back.sv =====
// back end: serial divide, clamp, round and result register
module cdl_back
   import cdl_pkg::*;
#(
   parameter int FRAC_BITS   = 16,
   parameter int COUNT_WIDTH = 32,
   parameter int TOTAL_WIDTH = 40
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [TOTAL_WIDTH-1:0]          histogram_total,
   input  cdl_queue_status_type            q_status,
   input  logic [SUM_WIDTH+COUNT_WIDTH:0]  q_head_data,
   output logic                            q_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [FRAC_BITS:0]       rsp_lut_value,
   output logic                            rsp_last_out
);

   localparam int NUM_W = SUM_WIDTH + 1;
   localparam int REM_W = TOTAL_WIDTH + 1;
   localparam int Q_W   = FRAC_BITS + 1;
   localparam int CNT_W = $clog2(FRAC_BITS + 1);

   cdl_state_type       state_ff, state_in;
   logic [NUM_W-1:0]    num_ff, num_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [Q_W-1:0]      q_ff, q_in;
   logic [CNT_W-1:0]    bit_cnt_ff, bit_cnt_in;
   logic                last_ff, last_in;
   logic                clamp_ff, clamp_in;
   logic                zero_ff, zero_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [FRAC_BITS:0]  rsp_lut_value_ff, rsp_lut_value_in;
   logic                rsp_last_out_ff, rsp_last_out_in;

   logic [SUM_WIDTH-1:0]   head_sum;
   logic [COUNT_WIDTH-1:0] head_count;
   logic                   head_last;
   logic [REM_W-1:0]       den;
   logic [REM_W:0]         rem_shift;
   logic [REM_W:0]         rem_diff;
   logic                   rem_ge;
   logic                   out_free;
   logic [Q_W:0]           q_full;
   logic [Q_W:0]           q_rnd;
   logic [FRAC_BITS:0]     lut_calc;

   assign {head_sum, head_count, head_last} = q_head_data;
   assign den       = {histogram_total, 1'b0};
   assign rem_shift = {rem_ff, 1'b0};
   assign rem_diff  = rem_shift - {1'b0, den};
   assign rem_ge    = (rem_shift >= {1'b0, den});
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      q_full   = clamp_ff ? ((Q_W+1)'(1) << Q_W) : {1'b0, q_ff};
      q_rnd    = q_full + (Q_W+1)'(1);
      lut_calc = q_rnd[Q_W:1] - ((FRAC_BITS+1)'(1) << (FRAC_BITS - 1));
   end

   always_comb begin
      state_in         = state_ff;
      num_in           = num_ff;
      rem_in           = rem_ff;
      q_in             = q_ff;
      bit_cnt_in       = bit_cnt_ff;
      last_in          = last_ff;
      clamp_in         = clamp_ff;
      zero_in          = zero_ff;
      q_pop            = 1'b0;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_lut_value_in = rsp_lut_value_ff;
      rsp_last_out_in  = rsp_last_out_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               q_pop    = 1'b1;
               // midpoint count doubled: 2S - C
               num_in   = {head_sum, 1'b0} - NUM_W'(head_count);
               last_in  = head_last;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            zero_in    = (histogram_total == '0);
            clamp_in   = (num_ff >= NUM_W'(den));
            rem_in     = num_ff[REM_W-1:0];
            q_in       = '0;
            bit_cnt_in = CNT_W'(FRAC_BITS);
            if ((histogram_total == '0) || (num_ff >= NUM_W'(den))) begin
               state_in = ST_ROUND;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = rem_ge ? rem_diff[REM_W-1:0] : rem_shift[REM_W-1:0];
            q_in   = {q_ff[Q_W-2:0], rem_ge};
            if (bit_cnt_ff == '0) begin
               state_in = ST_ROUND;
            end else begin
               bit_cnt_in = bit_cnt_ff - 1'b1;
            end
         end
         ST_ROUND: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_lut_value_in = zero_ff ? '0 : lut_calc;
               rsp_last_out_in  = last_ff;
               state_in         = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff           <= num_in;
      rem_ff           <= rem_in;
      q_ff             <= q_in;
      bit_cnt_ff       <= bit_cnt_in;
      last_ff          <= last_in;
      clamp_ff         <= clamp_in;
      zero_ff          <= zero_in;
      rsp_lut_value_ff <= rsp_lut_value_in;
      rsp_last_out_ff  <= rsp_last_out_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_lut_value = rsp_lut_value_ff;
   assign rsp_last_out  = rsp_last_out_ff;

   // partial remainder stays below the divisor through the divide
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < den))
      else $error("divider remainder not below divisor");

   // a new result only comes out of the rounding step
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && rsp_stall)) |-> $past(state_ff == ST_ROUND))
      else $error("result word loaded outside rounding step");

   // zero total always yields a zero table entry
   a_zero_total: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && zero_ff && out_free) |=> (rsp_lut_value_ff == '0))
      else $error("zero total gave nonzero entry");

endmodule

// ===== rtl/core/code_density_lut_builder_unit.sv =====
// top level of the code density correction table builder
// Builds a time-to-digital converter correction table from a fine-time
// histogram. Program csr_write_data with the sum of all bin counts while the
// unit is idle, then send the bin counts in bin order on the req_ channel,
// flagging the final bin with req_last_bin. For every bin one rsp_ word comes
// back, in order: the bin's midpoint cumulative fraction (running sum minus
// half the bin's count, over the total), clamped to [0,1], minus one half, as
// a signed value with FRAC_BITS fraction bits rounded to nearest. A zero total
// yields zero entries. The running sum saturates at 2^48-1 and returns to zero
// after the last bin. From queue head to result register each word passes the
// check, divide and round steps of the back end, where a restoring divider
// forms one quotient bit per cycle; a zero total or a fraction clamped at one
// skips the divide. The front end keeps taking words into a two-entry queue
// meanwhile, and the result register holds a finished word while the next one
// is being divided.
module code_density_lut_builder_unit
   import cdl_pkg::*;
#(
   parameter int FRAC_BITS   = 16,
   parameter int COUNT_WIDTH = 32,
   parameter int TOTAL_WIDTH = 40
) (
   input  logic                       clock,
   input  logic                       reset,
   // total register write
   input  logic                       csr_write_enable,
   input  logic [TOTAL_WIDTH-1:0]     csr_write_data,
   // bin word input
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [COUNT_WIDTH-1:0]     req_bin_count,
   input  logic                       req_last_bin,
   // table word output
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [FRAC_BITS:0]  rsp_lut_value,
   output logic                       rsp_last_out
);

   // queue word: saturated sum, bin count, last flag
   localparam int QDATA_W = SUM_WIDTH + COUNT_WIDTH + 1;

   logic [TOTAL_WIDTH-1:0] histogram_total_ff;
   logic [TOTAL_WIDTH-1:0] histogram_total_in;
   cdl_queue_status_type   q_status;
   logic                   q_push;
   logic [QDATA_W-1:0]     q_push_data;
   logic                   q_pop;
   logic [QDATA_W-1:0]     q_head_data;

   // total register; the user must write it only while idle, the block does not enforce this
   assign histogram_total_in = csr_write_enable ? csr_write_data : histogram_total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         histogram_total_ff <= '0;
      end else begin
         histogram_total_ff <= histogram_total_in;
      end
   end

   // front: accept words, update running sum
   cdl_front #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_bin_count (req_bin_count),
      .req_last_bin  (req_last_bin),
      .q_status      (q_status),
      .q_push        (q_push),
      .q_push_data   (q_push_data)
   );

   // decoupling queue
   cdl_queue #(
      .DATA_WIDTH (QDATA_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head_data (q_head_data),
      .status    (q_status)
   );

   // back: divide, clamp, round, hold result
   cdl_back #(
      .FRAC_BITS   (FRAC_BITS),
      .COUNT_WIDTH (COUNT_WIDTH),
      .TOTAL_WIDTH (TOTAL_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .histogram_total (histogram_total_ff),
      .q_status        (q_status),
      .q_head_data     (q_head_data),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_lut_value   (rsp_lut_value),
      .rsp_last_out    (rsp_last_out)
   );

endmodule
